/* sv/apbr_pkg.sv */
// Shared types and list codes for the adaptive page buffer replacement core.
// No dependencies; imported by the top level.
package apbr_pkg;

  localparam int PAGE_W = 12;
  localparam int ADV_W  = 6;
  localparam int OUT_FW = 4;

  typedef logic [PAGE_W-1:0]       page_t;
  typedef logic [2:0]              list_t;
  typedef logic signed [ADV_W-1:0] adv_t;
  typedef logic [OUT_FW-1:0]       frame_out_t;

  localparam list_t L_RD_REC  = 3'd0;
  localparam list_t L_RD_FRQ  = 3'd1;
  localparam list_t L_RD_FREE = 3'd2;
  localparam list_t L_WR_REC  = 3'd3;
  localparam list_t L_WR_FRQ  = 3'd4;
  localparam list_t L_WR_FREE = 3'd5;
  localparam list_t L_NONE    = 3'd7;

  localparam adv_t ADV_MAX = 6'sd31;
  localparam adv_t ADV_MIN = -6'sd32;

endpackage

/* sv/apbr_ram.sv */
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module apbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/adaptive_page_buffer_replacement_core.sv */
// Adaptive page buffer replacement core: read/write area split of FRAMES frames.
// Depends on apbr_pkg and apbr_ram.
//
// Usage: present page_id and req_type with start high; the item is taken at an
// edge where start is high and busy is low. busy stays high while the item is
// worked on. The result appears for exactly one cycle with done high: hit,
// frame, ghost_hit, evicted_valid, evicted_page and fail. The receiver cannot
// hold results off and need not: each result is registered and the next item
// may be taken in the same cycle that done is high.
// The frame table lives in a RAM that is walked one entry per cycle; every list
// search or list unlink is one walk of all FRAMES entries, except an LRU search
// of an empty list, which skips the walk. The next item is taken only after
// the previous result. Use counts live in a second RAM of NUM_PAGES entries.
// After reset a clearing pass over max(NUM_PAGES, FRAMES) addresses initialises
// both RAMs with busy high; all lists, limits, advisors and ghost FIFOs return
// to their reset contents.
module adaptive_page_buffer_replacement_core #(
  parameter int FRAMES      = 16,
  parameter int NUM_PAGES   = 4096,
  parameter int GHOST_DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  apbr_pkg::page_t       page_id,
  input  logic                  req_type,
  output logic                  done,
  output logic                  hit,
  output apbr_pkg::frame_out_t  frame,
  output logic                  ghost_hit,
  output logic                  evicted_valid,
  output apbr_pkg::page_t       evicted_page,
  output logic                  fail
);
  import apbr_pkg::*;

  localparam int FW   = $clog2(FRAMES);
  localparam int CW   = FW + 5;
  localparam int FEW  = 3 + FW + PAGE_W;
  localparam int PW   = $clog2(NUM_PAGES);
  localparam int CLRN = (NUM_PAGES > FRAMES) ? NUM_PAGES : FRAMES;
  localparam int CLW  = $clog2(CLRN);
  localparam int HALF = FRAMES / 2;
  localparam int GD   = GHOST_DEPTH;
  localparam int GCW  = $clog2(GD + 1);
  localparam int GIW  = (GD > 1) ? $clog2(GD) : 1;

  localparam logic signed [CW-1:0] ONE  = CW'(1);
  localparam logic signed [CW-1:0] ZERO = CW'(0);

  localparam logic [1:0] OP_LRU    = 2'd0;
  localparam logic [1:0] OP_FIND   = 2'd1;
  localparam logic [1:0] OP_UNLINK = 2'd2;

  localparam logic [5:0] S_IDLE = 6'd0,  S_CLR  = 6'd1,  S_LOAD = 6'd2,  S_RB0  = 6'd3,
                         S_RB1  = 6'd4,  S_RB2  = 6'd5,  S_RB3  = 6'd6,  S_RBSR = 6'd7,
                         S_RBSW = 6'd8,  S_LAW  = 6'd9,  S_LAR  = 6'd10, S_NM0  = 6'd11,
                         S_NM1  = 6'd12, S_NM2  = 6'd13, S_H0   = 6'd14, S_H1   = 6'd15,
                         S_H2   = 6'd16, S_H3   = 6'd17, S_H3B  = 6'd18, S_H4   = 6'd19,
                         S_H4B  = 6'd20, S_HEND = 6'd21, S_GH   = 6'd22, S_WRCK = 6'd23,
                         S_MW1  = 6'd24, S_MW2  = 6'd25, S_MW2B = 6'd26, S_MW3  = 6'd27,
                         S_MW3B = 6'd28, S_FIN  = 6'd29, S_PL0  = 6'd30, S_PL1  = 6'd31,
                         S_PL2  = 6'd32, S_PLOK = 6'd33, S_PUT  = 6'd34, S_SWS  = 6'd35,
                         S_SW   = 6'd36;

  logic [5:0] state;

  logic signed [CW-1:0] cnt  [6];
  logic signed [CW-1:0] lim  [6];
  logic signed [CW-1:0] area [2];
  logic signed [CW-1:0] pr, pw;
  adv_t                 adv  [3];

  page_t             gmem [4][GD];
  logic [GCW-1:0]    gcnt [4];

  page_t             page_q, pg, ev_pg;
  logic              wr_q, hit_q, gh_q, ev_v, blk_v, f_fnd;
  logic [1:0]        uses_q;
  logic [FW-1:0]     blk_idx, f_idx, f_ord;
  logic [1:0]        sw_op;
  list_t             sw_list, put_list, pl_list;
  logic [5:0]        sw_ret, put_ret, pl_ret;
  logic              put_force;
  logic [FW:0]       sw_iss;
  logic              sw_pv;
  logic [FW-1:0]     sw_pidx;
  logic              rb_src, rb_first;
  logic [1:0]        nm_k;
  logic [CLW-1:0]    clr_idx;

  logic              fw_we;
  logic [FW-1:0]     fw_addr;
  logic [FEW-1:0]    fw_data;
  logic [FEW-1:0]    fr_rdata;

  logic              u_we;
  logic [PW-1:0]     u_waddr;
  logic [1:0]        u_wdata, u_rdata;

  // frame table and use-count memories
  apbr_ram #(.WIDTH(FEW), .DEPTH(FRAMES)) u_frame_ram (
    .clk(clk), .we(fw_we), .waddr(fw_addr), .wdata(fw_data),
    .raddr(sw_iss[FW-1:0]), .rdata(fr_rdata)
  );

  apbr_ram #(.WIDTH(2), .DEPTH(NUM_PAGES)) u_uses_ram (
    .clk(clk), .we(u_we), .waddr(u_waddr), .wdata(u_wdata),
    .raddr(PW'(page_id)), .rdata(u_rdata)
  );

  always_comb begin
    if (state == S_CLR) begin
      u_we    = 1'b1;
      u_waddr = PW'(clr_idx);
      u_wdata = 2'd0;
    end else begin
      u_we    = (state == S_FIN) && blk_v && (uses_q < 2'd2);
      u_waddr = PW'(page_q);
      u_wdata = uses_q + 2'd1;
    end
  end

  function automatic logic signed [CW-1:0] quarter(input logic signed [CW-1:0] x);
    quarter = x[CW-1] ? -((-x) >>> 2) : (x >>> 2);
  endfunction

  function automatic adv_t adv_up(input adv_t v);
    adv_up = (v == ADV_MAX) ? v : v + 6'sd1;
  endfunction

  function automatic adv_t adv_dn(input adv_t v);
    adv_dn = (v == ADV_MIN) ? v : v - 6'sd1;
  endfunction

  // table entry fields
  list_t         e_own;
  logic [FW-1:0] e_ord;
  page_t         e_pg;
  logic          lru_now, find_now, sw_last;

  assign e_own    = fr_rdata[FEW-1 -: 3];
  assign e_ord    = fr_rdata[PAGE_W +: FW];
  assign e_pg     = fr_rdata[PAGE_W-1:0];
  assign lru_now  = sw_pv && (sw_op == OP_LRU) && (e_own == sw_list) &&
                    (e_ord == '0) && !f_fnd;
  assign find_now = sw_pv && (sw_op == OP_FIND) && (e_own == sw_list) &&
                    (e_pg == page_q) && (!f_fnd || (e_ord < f_ord));
  assign sw_last  = sw_pv && (sw_pidx == FW'(FRAMES - 1));

  logic signed [CW-1:0] used_rd, used_wr, put_used, put_area, pl_used, pl_area;
  logic                 put_ok, pl_room;

  assign used_rd  = cnt[L_RD_REC] + cnt[L_RD_FRQ];
  assign used_wr  = cnt[L_WR_REC] + cnt[L_WR_FRQ];
  assign put_used = (put_list >= L_WR_REC) ? used_wr : used_rd;
  assign put_area = (put_list >= L_WR_REC) ? area[1] : area[0];
  assign put_ok   = f_fnd && (put_force ||
                    ((put_used < put_area) && (cnt[put_list] < lim[put_list])));
  assign pl_used  = (pl_list >= L_WR_REC) ? used_wr : used_rd;
  assign pl_area  = (pl_list >= L_WR_REC) ? area[1] : area[0];
  assign pl_room  = (pl_used < pl_area) && (cnt[pl_list] < lim[pl_list]);

  // normalise one limit pair
  list_t                nm_base, nm_l, nm_o, nm_free;
  logic signed [CW-1:0] nm_ll, nm_lo;

  always_comb begin
    nm_base = nm_k[1] ? L_WR_REC : L_RD_REC;
    nm_l    = nm_base + {2'b00, nm_k[0]};
    nm_o    = nm_base + {2'b00, ~nm_k[0]};
    nm_free = nm_base + 3'd2;
    nm_ll   = lim[nm_l];
    nm_lo   = lim[nm_o];
    if (nm_ll <= ZERO) begin
      nm_lo = nm_lo - (ONE - nm_ll);
      nm_ll = ONE;
    end
    if (nm_lo <= ZERO) begin
      nm_ll = nm_ll - (ONE - nm_lo);
      nm_lo = ONE;
    end
  end

  // one advisor step on an area's limits
  logic                 la_a;
  adv_t                 la_adv;
  logic signed [CW-1:0] la_r, la_q;

  always_comb begin
    la_a   = (state == S_LAW);
    la_adv = la_a ? adv[1] : adv[2];
    la_r   = la_a ? lim[L_WR_REC] : lim[L_RD_REC];
    la_q   = la_a ? lim[L_WR_FRQ] : lim[L_RD_FRQ];
    if (la_adv > 6'sd0) begin
      la_q = la_q + ONE;
      if (la_r + la_q > area[la_a]) la_r = area[la_a] - la_q;
    end else begin
      la_r = la_r + ONE;
      if (la_r + la_q > area[la_a]) la_q = area[la_a] - la_r;
    end
  end

  // split an area's size change over its two limits
  logic                 sp_a;
  logic signed [CW-1:0] sp_d, sp_big, sp_small, sp_r, sp_q;

  always_comb begin
    sp_a = (state == S_RBSW);
    sp_d = area[sp_a] - (sp_a ? pw : pr);
    sp_r = sp_a ? lim[L_WR_REC] : lim[L_RD_REC];
    sp_q = sp_a ? lim[L_WR_FRQ] : lim[L_RD_FRQ];
    if (sp_d > ZERO) begin
      sp_big   = sp_d;
      sp_small = sp_d - ONE;
    end else begin
      sp_big   = sp_d + ONE;
      sp_small = sp_d;
    end
    if (!sp_d[0]) begin
      sp_r = sp_r + sp_d;
      sp_q = sp_q + sp_d;
    end else if (sp_r > sp_q) begin
      sp_r = sp_r + sp_big;
      sp_q = sp_q + sp_small;
    end else begin
      sp_r = sp_r + sp_small;
      sp_q = sp_q + sp_big;
    end
  end

  // ghost FIFO search
  logic [GD-1:0]  gm [4];
  logic           g_any;
  logic [1:0]     g_sel, g_push;
  logic [GIW-1:0] g_pos;

  always_comb begin
    g_any = 1'b0;
    g_sel = 2'd0;
    g_pos = '0;
    for (int g = 0; g < 4; g++) begin
      for (int i = 0; i < GD; i++) begin
        gm[g][i] = (GCW'(i) < gcnt[g]) && (gmem[g][i] == page_q);
      end
    end
    for (int g = 3; g >= 0; g--) begin
      if (|gm[g]) begin
        g_any = 1'b1;
        g_sel = 2'(g);
      end
    end
    for (int i = GD - 1; i >= 0; i--) begin
      if (gm[g_sel][i]) g_pos = GIW'(i);
    end
    g_push = (pl_list >= L_WR_REC) ? 2'(pl_list - 3'd1) : 2'(pl_list);
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    fw_we <= 1'b0;
    done  <= 1'b0;
    if (rst) begin
      state   <= S_CLR;
      clr_idx <= '0;
      for (int a = 0; a < 2; a++) begin
        cnt[a*3]   <= ZERO;
        cnt[a*3+1] <= ZERO;
      end
      cnt[L_RD_FREE] <= CW'(FRAMES - HALF);
      cnt[L_WR_FREE] <= CW'(HALF);
      lim[L_RD_REC]  <= CW'((FRAMES - HALF) / 2);
      lim[L_RD_FRQ]  <= CW'((FRAMES - HALF) / 2);
      lim[L_RD_FREE] <= CW'(FRAMES - HALF);
      lim[L_WR_REC]  <= CW'(HALF / 2);
      lim[L_WR_FRQ]  <= CW'(HALF / 2);
      lim[L_WR_FREE] <= CW'(HALF);
      area[0] <= CW'(FRAMES - HALF);
      area[1] <= CW'(HALF);
      for (int i = 0; i < 3; i++) adv[i] <= '0;
      for (int g = 0; g < 4; g++) gcnt[g] <= '0;
    end else begin
      unique case (state)
        S_CLR: begin
          if (CLW'(clr_idx) < CLW'(FRAMES) || CLRN == FRAMES) begin
            fw_we   <= 1'b1;
            fw_addr <= FW'(clr_idx);
            if (clr_idx < CLW'(HALF)) begin
              fw_data <= {L_WR_FREE, FW'(clr_idx), {PAGE_W{1'b0}}};
            end else begin
              fw_data <= {L_RD_FREE, FW'(clr_idx - CLW'(HALF)), {PAGE_W{1'b0}}};
            end
          end
          if (clr_idx == CLW'(CLRN - 1)) state <= S_IDLE;
          else clr_idx <= clr_idx + 1'b1;
        end
        S_IDLE: begin
          if (start) begin
            page_q <= page_id;
            wr_q   <= req_type;
            hit_q  <= 1'b0;
            gh_q   <= 1'b0;
            ev_v   <= 1'b0;
            blk_v  <= 1'b0;
            state  <= S_LOAD;
          end
        end
        S_LOAD: begin
          uses_q <= u_rdata;
          if (used_rd < CW'(FRAMES)) begin
            pr    <= area[0];
            pw    <= area[1];
            state <= S_RB0;
          end else begin
            state <= S_H0;
          end
        end
        S_RB0: begin
          sw_op  <= OP_LRU;
          sw_ret <= S_RB1;
          if (adv[0] > 6'sd0) begin
            adv[0]         <= adv[0] - 6'sd1;
            rb_src         <= 1'b0;
            area[1]        <= area[1] + ONE;
            lim[L_WR_FREE] <= lim[L_WR_FREE] + ONE;
            lim[L_RD_FREE] <= lim[L_RD_FREE] - ONE;
            area[0]        <= area[0] - ONE;
            sw_list        <= L_RD_FREE;
            state          <= S_SWS;
          end else if (adv[0] < 6'sd0) begin
            adv[0]         <= adv[0] + 6'sd1;
            rb_src         <= 1'b1;
            area[0]        <= area[0] + ONE;
            lim[L_RD_FREE] <= lim[L_RD_FREE] + ONE;
            lim[L_WR_FREE] <= lim[L_WR_FREE] - ONE;
            area[1]        <= area[1] - ONE;
            sw_list        <= L_WR_FREE;
            state          <= S_SWS;
          end else begin
            state <= S_RBSR;
          end
        end
        S_RB1: begin
          put_list  <= rb_src ? L_RD_FREE : L_WR_FREE;
          put_force <= 1'b0;
          put_ret   <= S_RB0;
          if (f_fnd) begin
            state <= S_PUT;
          end else begin
            rb_first <= ((rb_src ? adv[1] : adv[2]) < 6'sd0);
            sw_op    <= OP_LRU;
            sw_list  <= (rb_src ? L_WR_REC : L_RD_REC) +
                        {2'b00, ((rb_src ? adv[1] : adv[2]) < 6'sd0)};
            sw_ret   <= S_RB2;
            state    <= S_SWS;
          end
        end
        S_RB2: begin
          if (f_fnd) begin
            state <= S_PUT;
          end else begin
            sw_op   <= OP_LRU;
            sw_list <= (rb_src ? L_WR_REC : L_RD_REC) + {2'b00, ~rb_first};
            sw_ret  <= S_RB3;
            state   <= S_SWS;
          end
        end
        S_RB3: state <= S_PUT;
        S_RBSR: begin
          lim[L_RD_REC] <= sp_r;
          lim[L_RD_FRQ] <= sp_q;
          state         <= S_RBSW;
        end
        S_RBSW: begin
          lim[L_WR_REC] <= sp_r;
          lim[L_WR_FRQ] <= sp_q;
          state         <= S_LAW;
        end
        S_LAW, S_LAR: begin
          if (la_adv != 6'sd0) begin
            if (la_a) adv[1] <= (la_adv > 6'sd0) ? la_adv - 6'sd1 : la_adv + 6'sd1;
            else      adv[2] <= (la_adv > 6'sd0) ? la_adv - 6'sd1 : la_adv + 6'sd1;
            lim[la_a ? L_WR_REC : L_RD_REC] <= la_r;
            lim[la_a ? L_WR_FRQ : L_RD_FRQ] <= la_q;
          end else if (la_a) begin
            state <= S_LAR;
          end else begin
            nm_k  <= 2'd0;
            state <= S_NM0;
          end
        end
        S_NM0: begin
          lim[nm_l] <= nm_ll;
          lim[nm_o] <= nm_lo;
          state     <= S_NM1;
        end
        S_NM1: begin
          if (cnt[nm_l] > lim[nm_l]) begin
            sw_op   <= OP_LRU;
            sw_list <= nm_l;
            sw_ret  <= S_NM2;
            state   <= S_SWS;
          end else if (nm_k == 2'd3) begin
            state <= S_H0;
          end else begin
            nm_k  <= nm_k + 2'd1;
            state <= S_NM0;
          end
        end
        S_NM2: begin
          if (f_fnd) begin
            put_list  <= nm_free;
            put_force <= 1'b0;
            put_ret   <= S_NM1;
            state     <= S_PUT;
          end else if (nm_k == 2'd3) begin
            state <= S_H0;
          end else begin
            nm_k  <= nm_k + 2'd1;
            state <= S_NM0;
          end
        end
        S_H0: begin
          sw_op   <= OP_FIND;
          sw_list <= L_RD_FRQ;
          sw_ret  <= S_H1;
          state   <= S_SWS;
        end
        S_H1, S_H2: begin
          if (f_fnd) begin
            blk_v     <= 1'b1;
            blk_idx   <= f_idx;
            put_list  <= (state == S_H1) ? L_RD_FRQ : L_WR_FRQ;
            put_force <= 1'b0;
            put_ret   <= S_HEND;
            state     <= S_PUT;
          end else begin
            sw_op   <= OP_FIND;
            sw_list <= (state == S_H1) ? L_WR_FRQ : L_RD_REC;
            sw_ret  <= (state == S_H1) ? S_H2 : S_H3;
            state   <= S_SWS;
          end
        end
        S_H3: begin
          if (f_fnd) begin
            put_list  <= L_RD_FREE;
            put_force <= 1'b0;
            put_ret   <= S_H3B;
            state     <= S_PUT;
          end else begin
            sw_op   <= OP_FIND;
            sw_list <= L_WR_REC;
            sw_ret  <= S_H4;
            state   <= S_SWS;
          end
        end
        S_H3B: begin
          pl_list <= L_RD_FRQ;
          pl_ret  <= S_HEND;
          state   <= S_PL0;
        end
        S_H4: begin
          if (f_fnd) begin
            put_list  <= L_WR_FREE;
            put_force <= 1'b0;
            put_ret   <= S_H4B;
            state     <= S_PUT;
          end else begin
            state <= S_HEND;
          end
        end
        S_H4B: begin
          pl_list <= L_WR_FRQ;
          pl_ret  <= S_HEND;
          state   <= S_PL0;
        end
        S_HEND: begin
          if (blk_v) begin
            hit_q <= 1'b1;
            state <= S_WRCK;
          end else begin
            state <= S_GH;
          end
        end
        S_GH: begin
          if (g_any) begin
            gh_q <= 1'b1;
            for (int i = 0; i < GD - 1; i++) begin
              if (i >= int'(g_pos)) gmem[g_sel][i] <= gmem[g_sel][i+1];
            end
            gcnt[g_sel] <= gcnt[g_sel] - 1'b1;
            case (g_sel)
              2'd0: begin
                if (area[1] > quarter(area[0])) adv[0] <= adv_dn(adv[0]);
                adv[2] <= adv_dn(adv[2]);
              end
              2'd1: begin
                if (area[1] > quarter(area[0])) adv[0] <= adv_dn(adv[0]);
                adv[2] <= adv_up(adv[2]);
              end
              2'd2: begin
                if (area[0] > quarter(area[1])) adv[0] <= adv_up(adv[0]);
                adv[1] <= adv_dn(adv[1]);
              end
              default: begin
                if (area[0] > quarter(area[1])) adv[0] <= adv_up(adv[0]);
                adv[1] <= adv_up(adv[1]);
              end
            endcase
          end
          pl_list <= g_any ? L_RD_FRQ : L_RD_REC;
          pl_ret  <= S_WRCK;
          state   <= S_PL0;
        end
        S_WRCK: begin
          if (blk_v && wr_q) begin
            sw_op   <= OP_FIND;
            sw_list <= L_WR_FRQ;
            sw_ret  <= S_MW1;
            state   <= S_SWS;
          end else begin
            state <= S_FIN;
          end
        end
        S_MW1: begin
          if (f_fnd) begin
            blk_idx   <= f_idx;
            put_list  <= L_WR_FRQ;
            put_force <= 1'b0;
            put_ret   <= S_FIN;
            state     <= S_PUT;
          end else begin
            sw_op   <= OP_FIND;
            sw_list <= L_RD_REC;
            sw_ret  <= S_MW2;
            state   <= S_SWS;
          end
        end
        S_MW2: begin
          if (f_fnd) begin
            put_list  <= L_RD_FREE;
            put_force <= 1'b0;
            put_ret   <= S_MW2B;
            state     <= S_PUT;
          end else begin
            sw_op   <= OP_FIND;
            sw_list <= L_RD_FRQ;
            sw_ret  <= S_MW3;
            state   <= S_SWS;
          end
        end
        S_MW2B: begin
          pl_list <= (uses_q > 2'd1) ? L_WR_FRQ : L_WR_REC;
          pl_ret  <= S_FIN;
          state   <= S_PL0;
        end
        S_MW3: begin
          if (f_fnd) begin
            put_list  <= L_RD_FREE;
            put_force <= 1'b0;
            put_ret   <= S_MW3B;
            state     <= S_PUT;
          end else begin
            blk_v <= 1'b0;
            state <= S_FIN;
          end
        end
        S_MW3B: begin
          pl_list <= L_WR_FRQ;
          pl_ret  <= S_FIN;
          state   <= S_PL0;
        end
        S_FIN: begin
          done          <= 1'b1;
          hit           <= hit_q;
          frame         <= blk_v ? OUT_FW'(blk_idx) : '0;
          ghost_hit     <= gh_q;
          evicted_valid <= ev_v;
          evicted_page  <= ev_v ? ev_pg : '0;
          fail          <= !blk_v;
          state         <= S_IDLE;
        end
        S_PL0: begin
          sw_op   <= OP_LRU;
          sw_list <= pl_room ? ((pl_list >= L_WR_REC) ? L_WR_FREE : L_RD_FREE) : pl_list;
          sw_ret  <= pl_room ? S_PL1 : S_PL2;
          state   <= S_SWS;
        end
        S_PL1: begin
          if (!f_fnd) begin
            blk_v <= 1'b0;
            state <= pl_ret;
          end else begin
            pg        <= page_q;
            put_list  <= pl_list;
            put_force <= 1'b0;
            put_ret   <= S_PLOK;
            state     <= S_PUT;
          end
        end
        S_PL2: begin
          if (!f_fnd) begin
            blk_v <= 1'b0;
            state <= pl_ret;
          end else begin
            ev_v  <= 1'b1;
            ev_pg <= pg;
            if (gcnt[g_push] >= GCW'(GD)) begin
              for (int i = 0; i < GD - 1; i++) gmem[g_push][i] <= gmem[g_push][i+1];
              gmem[g_push][GD-1] <= pg;
            end else begin
              for (int i = 0; i < GD; i++) begin
                if (GCW'(i) == gcnt[g_push]) gmem[g_push][i] <= pg;
              end
              gcnt[g_push] <= gcnt[g_push] + 1'b1;
            end
            pg        <= page_q;
            put_list  <= pl_list;
            put_force <= 1'b1;
            put_ret   <= S_PLOK;
            state     <= S_PUT;
          end
        end
        S_PLOK: begin
          blk_v   <= 1'b1;
          blk_idx <= f_idx;
          state   <= pl_ret;
        end
        S_PUT: begin
          if (put_ok) begin
            fw_we         <= 1'b1;
            fw_addr       <= f_idx;
            fw_data       <= {put_list, FW'(cnt[put_list]), pg};
            cnt[put_list] <= cnt[put_list] + ONE;
          end
          state <= put_ret;
        end
        S_SWS: begin
          if (sw_op != OP_UNLINK) f_fnd <= 1'b0;
          if (sw_op == OP_LRU && cnt[sw_list] <= ZERO) begin
            state <= sw_ret;
          end else begin
            sw_iss <= '0;
            sw_pv  <= 1'b0;
            state  <= S_SW;
          end
        end
        S_SW: begin
          if (sw_iss < (FW+1)'(FRAMES)) sw_iss <= sw_iss + 1'b1;
          sw_pv   <= (sw_iss < (FW+1)'(FRAMES));
          sw_pidx <= sw_iss[FW-1:0];
          if (sw_pv && e_own == sw_list) begin
            case (sw_op)
              OP_LRU: begin
                if (lru_now) begin
                  f_fnd   <= 1'b1;
                  f_idx   <= sw_pidx;
                  pg      <= e_pg;
                  fw_we   <= 1'b1;
                  fw_addr <= sw_pidx;
                  fw_data <= {L_NONE, {FW{1'b0}}, e_pg};
                end else if (e_ord != '0) begin
                  fw_we   <= 1'b1;
                  fw_addr <= sw_pidx;
                  fw_data <= {e_own, e_ord - 1'b1, e_pg};
                end
              end
              OP_FIND: begin
                if (find_now) begin
                  f_fnd <= 1'b1;
                  f_idx <= sw_pidx;
                  f_ord <= e_ord;
                end
              end
              default: begin
                if (sw_pidx == f_idx) begin
                  fw_we   <= 1'b1;
                  fw_addr <= sw_pidx;
                  fw_data <= {L_NONE, {FW{1'b0}}, e_pg};
                end else if (e_ord > f_ord) begin
                  fw_we   <= 1'b1;
                  fw_addr <= sw_pidx;
                  fw_data <= {e_own, e_ord - 1'b1, e_pg};
                end
              end
            endcase
          end
          if (sw_last) begin
            case (sw_op)
              OP_LRU: begin
                if (f_fnd || lru_now) cnt[sw_list] <= cnt[sw_list] - ONE;
                state <= sw_ret;
              end
              OP_FIND: begin
                if (f_fnd || find_now) begin
                  pg    <= page_q;
                  sw_op <= OP_UNLINK;
                  state <= S_SWS;
                end else begin
                  state <= sw_ret;
                end
              end
              default: begin
                cnt[sw_list] <= cnt[sw_list] - ONE;
                state        <= sw_ret;
              end
            endcase
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* verif/tb_adaptive_page_buffer_replacement_core.sv */
// Self-checking testbench for adaptive_page_buffer_replacement_core: a directed table then
// random page streams, each result checked against a cycle-free predictor of the frame lists
// or, for typed table rows, against the table entry. Depends on apbr_pkg and the core RTL.
module tb_adaptive_page_buffer_replacement_core;
  import apbr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NFR = 16;
  localparam int NPG = 4096;
  localparam int GDEP = 4;
  localparam int AREA_RD = 0;
  localparam int AREA_WR = 1;
  localparam int OFS_REC = 0;
  localparam int OFS_FRQ = 1;
  localparam int OFS_FREE = 2;
  localparam int ADV_AREA = 0;
  localparam int ADV_WFRQ = 1;
  localparam int ADV_RFRQ = 2;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int RAND_ITEMS = 1700;
  localparam int POOL = 24;

  typedef struct packed {
    logic       hit;
    frame_out_t frame;
    logic       ghost_hit;
    logic       ev_valid;
    page_t      ev_page;
    logic       fail;
  } access_res_t;

  typedef struct packed {
    page_t       pg;
    logic        wr;
    logic        typed;
    access_res_t res;
  } dir_row_t;

  logic clk = 0, rst = 1, start = 0, req_type = 0;
  page_t page_id = '0;
  logic busy, done, hit, ghost_hit, evicted_valid, fail;
  frame_out_t frame;
  page_t evicted_page;

  logic cur_typed = 0;
  access_res_t cur_res = '0;

  adaptive_page_buffer_replacement_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .page_id(page_id),
    .req_type(req_type), .done(done), .hit(hit), .frame(frame), .ghost_hit(ghost_hit),
    .evicted_valid(evicted_valid), .evicted_page(evicted_page), .fail(fail)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // predictor state
  page_t frm_page [NFR];
  int    frm_list [NFR];
  int    frm_pos  [NFR];
  int    lst_cnt  [6];
  int    lst_lim  [6];
  int    area_lim [2];
  page_t gh_fifo  [4][GDEP];
  int    gh_len   [4];
  int    adv      [3];
  int    use_cnt  [NPG];
  logic  ev_flag;
  page_t ev_pg;

  access_res_t pending_q [$];
  int errors = 0;
  int cycles = 0;
  int idle_pct = 0;

  function automatic int lix(int a, int l);
    return a * 3 + l;
  endfunction

  function automatic int area_used(int a);
    return lst_cnt[lix(a, OFS_REC)] + lst_cnt[lix(a, OFS_FRQ)];
  endfunction

  function automatic void detach(int f);
    int l;
    l = frm_list[f];
    for (int g = 0; g < NFR; g++)
      if (frm_list[g] == l && frm_pos[g] > frm_pos[f]) frm_pos[g]--;
    lst_cnt[l]--;
    frm_list[f] = int'(L_NONE);
    frm_pos[f] = 0;
  endfunction

  function automatic int pop_lru(int l);
    if (lst_cnt[l] <= 0) return -1;
    for (int f = 0; f < NFR; f++)
      if (frm_list[f] == l && frm_pos[f] == 0) begin
        detach(f);
        return f;
      end
    return -1;
  endfunction

  function automatic int pull_page(int l, page_t p);
    int best;
    best = -1;
    for (int f = 0; f < NFR; f++)
      if (frm_list[f] == l && frm_page[f] == p && (best < 0 || frm_pos[f] < frm_pos[best]))
        best = f;
    if (best >= 0) detach(best);
    return best;
  endfunction

  function automatic void link(int l, int f);
    frm_list[f] = l;
    frm_pos[f] = lst_cnt[l];
    lst_cnt[l]++;
  endfunction

  function automatic void insert(int l, int f);
    if (f < 0 || area_used(l / 3) >= area_lim[l / 3] || lst_cnt[l] >= lst_lim[l]) return;
    link(l, f);
  endfunction

  function automatic void ghost_push(int g, page_t p);
    if (gh_len[g] >= GDEP) begin
      for (int i = 0; i + 1 < GDEP; i++) gh_fifo[g][i] = gh_fifo[g][i+1];
      gh_len[g] = GDEP - 1;
    end
    gh_fifo[g][gh_len[g]] = p;
    gh_len[g]++;
  endfunction

  function automatic bit ghost_take(int g, page_t p);
    for (int i = 0; i < gh_len[g] && i < GDEP; i++)
      if (gh_fifo[g][i] == p) begin
        for (int j = i; j + 1 < gh_len[g]; j++) gh_fifo[g][j] = gh_fifo[g][j+1];
        gh_len[g]--;
        return 1;
      end
    return 0;
  endfunction

  function automatic int place_page(int a, int l, page_t p);
    int li, f;
    li = lix(a, l);
    if (area_used(a) < area_lim[a] && lst_cnt[li] < lst_lim[li]) begin
      f = pop_lru(lix(a, OFS_FREE));
      if (f < 0) return -1;
      frm_page[f] = p;
      insert(li, f);
      return f;
    end
    f = pop_lru(li);
    if (f < 0) return -1;
    ev_flag = 1;
    ev_pg = frm_page[f];
    ghost_push(a * 2 + l, frm_page[f]);
    frm_page[f] = p;
    link(li, f);
    return f;
  endfunction

  function automatic void adv_step(int i, int d);
    int v;
    v = adv[i] + d;
    adv[i] = v > int'(ADV_MAX) ? int'(ADV_MAX) : (v < int'(ADV_MIN) ? int'(ADV_MIN) : v);
  endfunction

  function automatic void trim(int a, int l);
    int li, lo, f;
    li = lix(a, l);
    lo = lix(a, 1 - l);
    if (lst_lim[li] <= 0) begin
      lst_lim[lo] -= 1 - lst_lim[li];
      lst_lim[li] = 1;
    end
    if (lst_lim[lo] <= 0) begin
      lst_lim[li] -= 1 - lst_lim[lo];
      lst_lim[lo] = 1;
    end
    while (lst_cnt[li] > lst_lim[li]) begin
      f = pop_lru(li);
      if (f < 0) break;
      insert(lix(a, OFS_FREE), f);
    end
  endfunction

  function automatic void split_delta(int a, int d);
    int big, sml;
    if (d % 2 == 0) begin
      lst_lim[lix(a, OFS_REC)] += d;
      lst_lim[lix(a, OFS_FRQ)] += d;
      return;
    end
    if (d > 0) begin
      big = d; sml = d - 1;
    end else begin
      big = d + 1; sml = d;
    end
    if (lst_lim[lix(a, OFS_REC)] > lst_lim[lix(a, OFS_FRQ)]) begin
      lst_lim[lix(a, OFS_REC)] += big; lst_lim[lix(a, OFS_FRQ)] += sml;
    end else begin
      lst_lim[lix(a, OFS_REC)] += sml; lst_lim[lix(a, OFS_FRQ)] += big;
    end
  endfunction

  function automatic void apply_list_adv(int a, int i);
    int r, q;
    r = lix(a, OFS_REC);
    q = lix(a, OFS_FRQ);
    while (adv[i] != 0) begin
      if (adv[i] > 0) begin
        adv[i]--; lst_lim[q]++;
        if (lst_lim[r] + lst_lim[q] > area_lim[a]) lst_lim[r] = area_lim[a] - lst_lim[q];
      end else begin
        adv[i]++; lst_lim[r]++;
        if (lst_lim[r] + lst_lim[q] > area_lim[a]) lst_lim[q] = area_lim[a] - lst_lim[r];
      end
    end
  endfunction

  function automatic void shift_frame(int src, int dst, int fadv);
    int f, first;
    area_lim[dst]++; lst_lim[lix(dst, OFS_FREE)]++;
    lst_lim[lix(src, OFS_FREE)]--; area_lim[src]--;
    f = pop_lru(lix(src, OFS_FREE));
    if (f < 0) begin
      first = adv[fadv] < 0 ? OFS_FRQ : OFS_REC;
      f = pop_lru(lix(src, first));
      if (f < 0) f = pop_lru(lix(src, 1 - first));
    end
    insert(lix(dst, OFS_FREE), f);
  endfunction

  function automatic void rebalance_areas();
    int pr, pw;
    pr = area_lim[AREA_RD];
    pw = area_lim[AREA_WR];
    while (adv[ADV_AREA] != 0) begin
      if (adv[ADV_AREA] > 0) begin
        adv[ADV_AREA]--; shift_frame(AREA_RD, AREA_WR, ADV_RFRQ);
      end else begin
        adv[ADV_AREA]++; shift_frame(AREA_WR, AREA_RD, ADV_WFRQ);
      end
    end
    split_delta(AREA_RD, area_lim[AREA_RD] - pr);
    split_delta(AREA_WR, area_lim[AREA_WR] - pw);
    apply_list_adv(AREA_WR, ADV_WFRQ);
    apply_list_adv(AREA_RD, ADV_RFRQ);
    trim(AREA_RD, OFS_REC); trim(AREA_RD, OFS_FRQ);
    trim(AREA_WR, OFS_REC); trim(AREA_WR, OFS_FRQ);
  endfunction

  function automatic bit check_ghosts(page_t p);
    if (ghost_take(0, p)) begin
      if (area_lim[AREA_WR] > area_lim[AREA_RD] / 4) adv_step(ADV_AREA, -1);
      adv_step(ADV_RFRQ, -1); return 1;
    end
    if (ghost_take(1, p)) begin
      if (area_lim[AREA_WR] > area_lim[AREA_RD] / 4) adv_step(ADV_AREA, -1);
      adv_step(ADV_RFRQ, 1); return 1;
    end
    if (ghost_take(2, p)) begin
      if (area_lim[AREA_RD] > area_lim[AREA_WR] / 4) adv_step(ADV_AREA, 1);
      adv_step(ADV_WFRQ, -1); return 1;
    end
    if (ghost_take(3, p)) begin
      if (area_lim[AREA_RD] > area_lim[AREA_WR] / 4) adv_step(ADV_AREA, 1);
      adv_step(ADV_WFRQ, 1); return 1;
    end
    return 0;
  endfunction

  function automatic int move_to_write(page_t p);
    int f;
    f = pull_page(int'(L_WR_FRQ), p);
    if (f >= 0) begin
      insert(int'(L_WR_FRQ), f); return f;
    end
    f = pull_page(int'(L_RD_REC), p);
    if (f >= 0) begin
      insert(int'(L_RD_FREE), f);
      return place_page(AREA_WR, use_cnt[p] > 1 ? OFS_FRQ : OFS_REC, p);
    end
    f = pull_page(int'(L_RD_FRQ), p);
    if (f >= 0) begin
      insert(int'(L_RD_FREE), f); return place_page(AREA_WR, OFS_FRQ, p);
    end
    return -1;
  endfunction

  function automatic void buffer_reset();
    for (int f = 0; f < NFR; f++) begin
      frm_page[f] = '0;
      frm_list[f] = f < NFR / 2 ? int'(L_WR_FREE) : int'(L_RD_FREE);
      frm_pos[f] = f < NFR / 2 ? f : f - NFR / 2;
    end
    for (int g = 0; g < 4; g++) gh_len[g] = 0;
    for (int i = 0; i < 3; i++) adv[i] = 0;
    for (int i = 0; i < NPG; i++) use_cnt[i] = 0;
    area_lim[AREA_WR] = NFR / 2;
    area_lim[AREA_RD] = NFR - NFR / 2;
    for (int a = 0; a < 2; a++) begin
      lst_cnt[lix(a, OFS_REC)] = 0;
      lst_cnt[lix(a, OFS_FRQ)] = 0;
      lst_cnt[lix(a, OFS_FREE)] = area_lim[a];
      lst_lim[lix(a, OFS_REC)] = area_lim[a] / 2;
      lst_lim[lix(a, OFS_FRQ)] = area_lim[a] / 2;
      lst_lim[lix(a, OFS_FREE)] = area_lim[a];
    end
  endfunction

  function automatic access_res_t predict_access(page_t p, logic wr);
    access_res_t r;
    int blk, f;
    bit gh;
    blk = -1;
    gh = 0;
    r = '0;
    ev_flag = 0;
    ev_pg = '0;
    if (area_used(AREA_RD) < NFR) rebalance_areas();
    f = pull_page(int'(L_RD_FRQ), p);
    if (f >= 0) begin
      insert(int'(L_RD_FRQ), f); blk = f;
    end else begin
      f = pull_page(int'(L_WR_FRQ), p);
      if (f >= 0) begin
        insert(int'(L_WR_FRQ), f); blk = f;
      end
    end
    if (blk < 0) begin
      f = pull_page(int'(L_RD_REC), p);
      if (f >= 0) begin
        insert(int'(L_RD_FREE), f); blk = place_page(AREA_RD, OFS_FRQ, p);
      end else begin
        f = pull_page(int'(L_WR_REC), p);
        if (f >= 0) begin
          insert(int'(L_WR_FREE), f); blk = place_page(AREA_WR, OFS_FRQ, p);
        end
      end
    end
    if (blk >= 0) r.hit = 1;
    else begin
      gh = check_ghosts(p);
      blk = place_page(AREA_RD, gh ? OFS_FRQ : OFS_REC, p);
    end
    if (blk >= 0 && wr) blk = move_to_write(p);
    if (blk >= 0 && use_cnt[p] < 2) use_cnt[p]++;
    r.frame = blk >= 0 ? frame_out_t'(blk) : '0;
    r.ghost_hit = gh;
    r.ev_valid = ev_flag;
    r.ev_page = ev_flag ? ev_pg : '0;
    r.fail = blk < 0;
    return r;
  endfunction

  always @(posedge clk) begin
    access_res_t want, got, pred;
    cycles <= cycles + 1;
    if (!rst && done) begin
      got = '{hit, frame, ghost_hit, evicted_valid, evicted_page, fail};
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors <= errors + 1;
      end else begin
        want = pending_q.pop_front();
        if (want.hit !== got.hit || want.frame !== got.frame ||
            want.ghost_hit !== got.ghost_hit || want.ev_valid !== got.ev_valid ||
            want.ev_page !== got.ev_page || want.fail !== got.fail) begin
          $display("%0t: mismatch exp hit=%0d frame=%0d gh=%0d ev=%0d evp=%0d fail=%0d",
                   $time, want.hit, want.frame, want.ghost_hit, want.ev_valid,
                   want.ev_page, want.fail);
          $display("%0t:          act hit=%0d frame=%0d gh=%0d ev=%0d evp=%0d fail=%0d",
                   $time, got.hit, got.frame, got.ghost_hit, got.ev_valid,
                   got.ev_page, got.fail);
          errors <= errors + 1;
        end
      end
    end
    if (!rst && start && !busy) begin
      pred = predict_access(page_id, req_type);
      pending_q.push_back(cur_typed ? cur_res : pred);
    end
  end

  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic issue(page_t p, logic wr, logic typed, access_res_t res);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    page_id <= p;
    req_type <= wr;
    cur_typed <= typed;
    cur_res <= res;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  dir_row_t dir_tab [22];

  initial begin
    page_t p;
    buffer_reset();
    dir_tab = '{
      '{12'd0,    1'b0, 1'b1, '{1'b0, 4'd8,  1'b0, 1'b0, 12'd0, 1'b0}},
      '{12'd4095, 1'b1, 1'b1, '{1'b0, 4'd0,  1'b0, 1'b0, 12'd0, 1'b0}},
      '{12'd0,    1'b0, 1'b1, '{1'b1, 4'd10, 1'b0, 1'b0, 12'd0, 1'b0}},
      '{12'd0,    1'b0, 1'b0, '0}, '{12'd0,    1'b1, 1'b0, '0},
      '{12'd1,    1'b0, 1'b0, '0}, '{12'd2,    1'b0, 1'b0, '0},
      '{12'd3,    1'b0, 1'b0, '0}, '{12'd4,    1'b0, 1'b0, '0},
      '{12'd5,    1'b0, 1'b0, '0}, '{12'd6,    1'b0, 1'b0, '0},
      '{12'd7,    1'b0, 1'b0, '0}, '{12'd8,    1'b0, 1'b0, '0},
      '{12'd9,    1'b0, 1'b0, '0}, '{12'd1,    1'b0, 1'b0, '0},
      '{12'd2,    1'b1, 1'b0, '0}, '{12'd4095, 1'b0, 1'b0, '0},
      '{12'd3,    1'b1, 1'b0, '0}, '{12'd5,    1'b0, 1'b0, '0},
      '{12'd4,    1'b0, 1'b0, '0}, '{12'd4095, 1'b1, 1'b0, '0},
      '{12'd2730, 1'b0, 1'b0, '0}
    };
    repeat (5) @(posedge clk);
    rst <= 0;
    foreach (dir_tab[i]) issue(dir_tab[i].pg, dir_tab[i].wr, dir_tab[i].typed, dir_tab[i].res);
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n < RAND_ITEMS / 3) idle_pct = 6;
      else if (n < 2 * RAND_ITEMS / 3) idle_pct = 65;
      else idle_pct = 0;
      if ($urandom_range(9) == 0) p = page_t'($urandom);
      else p = page_t'($urandom_range(POOL - 1) + ($urandom_range(1) ? 12'd4072 : 12'd0));
      issue(p, $urandom_range(2) == 0, 1'b0, '0);
    end
    start <= 0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
